@@ sv/sfts_pkg.sv @@
`timescale 1ns / 1ps

package sfts_pkg;

   localparam int FUNC_BITS   = 2;
   localparam int SENSOR_BITS = 3;
   localparam int DATA_BITS   = 32;
   localparam int COUNT_BITS  = 4;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   // item kinds
   localparam logic [FUNC_BITS-1:0] FUNC_SCHEDULE = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_WRAP     = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_CLEAR    = 2'd2;

   // register indexes (paddr[3:2])
   localparam logic [1:0] REG_MIN_FIRE_DELAY = 2'd0;
   localparam logic [1:0] REG_MIN_DELAY_DIFF = 2'd1;
   localparam logic [1:0] REG_DYNAMIC_TIMING = 2'd2;
   localparam logic [1:0] REG_SENSOR_COUNT   = 2'd3;

   localparam logic [DATA_BITS-1:0]  RESET_MIN_FIRE_DELAY = 32'd1000000;
   localparam logic [COUNT_BITS-1:0] RESET_SENSOR_COUNT   = 4'd8;

endpackage

@@ sv/sfts_chan_if.sv @@
`timescale 1ns / 1ps

interface sfts_req_if;
   logic                              valid;
   logic                              ready;
   logic [sfts_pkg::FUNC_BITS-1:0]    func;
   logic [sfts_pkg::SENSOR_BITS-1:0]  sensor;
   logic [sfts_pkg::DATA_BITS-1:0]    timer_now;

   modport source (output valid, func, sensor, timer_now, input ready);
   modport sink (input valid, func, sensor, timer_now, output ready);
endinterface

interface sfts_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [sfts_pkg::DATA_BITS-1:0]  fire_delay;
   logic [sfts_pkg::DATA_BITS-1:0]  fire_time;

   modport source (output valid, fire_delay, fire_time, input ready);
   modport sink (input valid, fire_delay, fire_time, output ready);
endinterface

@@ sv/sfts_ram.sv @@
`timescale 1ns / 1ps

module sfts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/sensor_fire_time_scheduler_unit.sv @@
`timescale 1ns / 1ps
// Fire-time scheduler for a group of ultrasonic sensors.
// req_bus carries one item a beat: func selects schedule, timer wrap or clear.
// A schedule item returns one beat on rsp_bus: the ticks to wait before
// firing and the chosen fire time; wrap and clear items return nothing.
// Registers are written over the csr_ APB port; the user must write them
// only while the block is idle, as the block itself does not enforce this.
// With dynamic timing on, a schedule item with n active sensors makes
// from 1 to n+1 passes, repeating while the fire time moved, each pass
// over the delay windows. Each phase walks the sensors one per cycle through
// the single read port of the fire-time, delay-row and window memories.
// The result sits in an output register; a new item is accepted while it
// waits, and a finished schedule item holds in its last step until that
// register is free, so a stalled receiver blocks no more than one result.
// Reset clears all fire times, delay rows, time offset and last sensor
// through valid bits and loads the register defaults.
module sensor_fire_time_scheduler_unit #(
   parameter int SENSORS   = 8,
   parameter int TIME_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   sfts_req_if.sink                           req_bus,
   sfts_rsp_if.source                         rsp_bus,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [sfts_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [sfts_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [sfts_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready
);

   localparam int IW     = (SENSORS > 1) ? $clog2(SENSORS) : 1;
   localparam int CW     = $clog2(SENSORS + 1);
   localparam int RDEPTH = SENSORS * SENSORS;
   localparam int RW     = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;
   localparam int TB     = TIME_BITS;

   typedef enum logic [11:0] {
      S_IDLE   = 12'b000000000001,
      S_MIN    = 12'b000000000010,
      S_TRIM   = 12'b000000000100,
      S_OFFS   = 12'b000000001000,
      S_CUR    = 12'b000000010000,
      S_PASS   = 12'b000000100000,
      S_GAP    = 12'b000001000000,
      S_PICK   = 12'b000010000000,
      S_PREP   = 12'b000100000000,
      S_SEARCH = 12'b001000000000,
      S_UPDATE = 12'b010000000000,
      S_COMMIT = 12'b100000000000
   } state_type;

   // configuration
   logic [31:0] mfd_ff, diff_ff;
   logic        dyn_ff;
   logic [3:0]  count_ff;
   logic        csr_wr;

   // control
   state_type         state_ff, state_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic              rv_ff, rv_in;
   logic [IW-1:0]     ri_ff, ri_in;
   logic              moved_ff, moved_in;
   logic [SENSORS-1:0] done_ff, done_in;
   logic [SENSORS-1:0] ft_vld_ff, ft_vld_in;
   logic [RDEPTH-1:0]  row_vld_ff, row_vld_in;
   logic [TB-1:0]     off_ff, off_in;
   logic [IW-1:0]     last_ff, last_in;
   logic              rsp_vld_ff, rsp_vld_in;

   // datapath
   logic [TB-1:0] low_ff, low_in;
   logic [TB-1:0] now_ff, now_in;
   logic [IW-1:0] s_ff, s_in;
   logic [TB-1:0] cur_ff, cur_in;
   logic [TB-1:0] ftl_ff, ftl_in;
   logic [TB-1:0] passed_ff, passed_in;
   logic [TB-1:0] gap_ff, gap_in;
   logic          ge_ff, ge_in;
   logic [TB-1:0] next_ff, next_in;
   logic [31:0]   rsp_delay_ff, rsp_delay_in;
   logic [31:0]   rsp_time_ff, rsp_time_in;

   // memories
   logic          ft_we;
   logic [IW-1:0] ft_waddr, ft_raddr;
   logic [TB-1:0] ft_wdata, ft_rdata;
   logic          row_we;
   logic [RW-1:0] row_raddr, row_iaddr, row_base;
   logic [TB-1:0] row_wdata, row_rdata;
   logic          win_we;
   logic [TB-1:0] win_wdata, win_rdata;

   logic [CW-1:0] n_act;
   logic          issue, rd_last, stream, req_acc;
   logic [TB-1:0] mfd_t, diff_t, ft_val, row_val, win_lo, win_hi;

   assign mfd_t  = TB'(mfd_ff);
   assign diff_t = TB'(diff_ff);

   always_comb begin
      if (32'(count_ff) > SENSORS) begin
         n_act = CW'(SENSORS);
      end else begin
         n_act = CW'(count_ff);
      end
   end

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_paddr[3:2])
         sfts_pkg::REG_MIN_FIRE_DELAY: csr_prdata = mfd_ff;
         sfts_pkg::REG_MIN_DELAY_DIFF: csr_prdata = diff_ff;
         sfts_pkg::REG_DYNAMIC_TIMING: csr_prdata = {31'd0, dyn_ff};
         sfts_pkg::REG_SENSOR_COUNT:   csr_prdata = {28'd0, count_ff};
         default:                      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mfd_ff   <= sfts_pkg::RESET_MIN_FIRE_DELAY;
         diff_ff  <= '0;
         dyn_ff   <= 1'b0;
         count_ff <= sfts_pkg::RESET_SENSOR_COUNT;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            sfts_pkg::REG_MIN_FIRE_DELAY: mfd_ff   <= csr_pwdata;
            sfts_pkg::REG_MIN_DELAY_DIFF: diff_ff  <= csr_pwdata;
            sfts_pkg::REG_DYNAMIC_TIMING: dyn_ff   <= csr_pwdata[0];
            sfts_pkg::REG_SENSOR_COUNT:   count_ff <= csr_pwdata[3:0];
            default: begin
            end
         endcase
      end
   end

   assign req_bus.ready      = (state_ff == S_IDLE);
   assign req_acc            = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid      = rsp_vld_ff;
   assign rsp_bus.fire_delay = rsp_delay_ff;
   assign rsp_bus.fire_time  = rsp_time_ff;

   assign stream  = (state_ff == S_MIN) || (state_ff == S_TRIM) || (state_ff == S_PREP) ||
                    (state_ff == S_SEARCH) || (state_ff == S_UPDATE);
   assign issue   = stream && (idx_ff < n_act);
   assign rd_last = rv_ff && ((CW'(ri_ff) + CW'(1)) == n_act);

   assign row_base  = RW'(s_ff) * RW'(SENSORS);
   assign row_raddr = row_base + RW'(idx_ff[IW-1:0]);
   assign row_iaddr = row_base + RW'(ri_ff);

   assign ft_val  = ft_vld_ff[ri_ff] ? ft_rdata : '0;
   assign row_val = row_vld_ff[row_iaddr] ? row_rdata : '0;
   assign win_lo  = win_rdata - diff_t;
   assign win_hi  = win_rdata + diff_t;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      rv_in        = 1'b0;
      ri_in        = ri_ff;
      moved_in     = moved_ff;
      done_in      = done_ff;
      ft_vld_in    = ft_vld_ff;
      row_vld_in   = row_vld_ff;
      off_in       = off_ff;
      last_in      = last_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_bus.ready;
      low_in       = low_ff;
      now_in       = now_ff;
      s_in         = s_ff;
      cur_in       = cur_ff;
      ftl_in       = ftl_ff;
      passed_in    = passed_ff;
      gap_in       = gap_ff;
      ge_in        = ge_ff;
      next_in      = next_ff;
      rsp_delay_in = rsp_delay_ff;
      rsp_time_in  = rsp_time_ff;
      ft_we        = 1'b0;
      ft_waddr     = ri_ff;
      ft_wdata     = ft_val - low_ff;
      ft_raddr     = idx_ff[IW-1:0];
      row_we       = 1'b0;
      row_wdata    = next_ff - ft_val;
      win_we       = 1'b0;
      win_wdata    = ft_val + row_val;

      // walk the sensors: one read issued and one read retired per cycle
      if (issue) begin
         idx_in = idx_ff + CW'(1);
         rv_in  = 1'b1;
         ri_in  = idx_ff[IW-1:0];
      end

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               case (req_bus.func)
                  sfts_pkg::FUNC_SCHEDULE: begin
                     if (32'(req_bus.sensor) < SENSORS) begin
                        s_in   = IW'(req_bus.sensor);
                        now_in = TB'(req_bus.timer_now);
                        low_in = off_ff;
                        idx_in = '0;
                        if (n_act != '0) begin
                           state_in = S_MIN;
                        end else begin
                           state_in = S_OFFS;
                        end
                     end
                  end
                  sfts_pkg::FUNC_WRAP: begin
                     off_in = off_ff + TB'(req_bus.timer_now);
                  end
                  sfts_pkg::FUNC_CLEAR: begin
                     off_in     = '0;
                     last_in    = '0;
                     ft_vld_in  = '0;
                     row_vld_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_MIN: begin
            if (rv_ff && (ft_val < low_ff)) begin
               low_in = ft_val;
            end
            if (rd_last) begin
               idx_in   = '0;
               state_in = S_TRIM;
            end
         end
         S_TRIM: begin
            if (rv_ff) begin
               ft_we            = 1'b1;
               ft_vld_in[ri_ff] = 1'b1;
            end
            if (rd_last) begin
               idx_in   = '0;
               state_in = S_OFFS;
            end
         end
         S_OFFS: begin
            off_in   = off_ff - low_ff;
            ft_raddr = last_ff;
            state_in = S_CUR;
         end
         S_CUR: begin
            cur_in   = off_ff + now_ff;
            ftl_in   = ft_vld_ff[last_ff] ? ft_rdata : '0;
            state_in = S_PASS;
         end
         S_PASS: begin
            passed_in = cur_ff - ftl_ff;
            state_in  = S_GAP;
         end
         S_GAP: begin
            ge_in    = (passed_ff >= mfd_t);
            gap_in   = mfd_t - passed_ff;
            state_in = S_PICK;
         end
         S_PICK: begin
            next_in  = ge_ff ? cur_ff : (cur_ff + gap_ff);
            done_in  = '0;
            moved_in = 1'b0;
            idx_in   = '0;
            if (n_act == '0) begin
               state_in = S_COMMIT;
            end else if (dyn_ff) begin
               state_in = S_PREP;
            end else begin
               state_in = S_UPDATE;
            end
         end
         S_PREP: begin
            win_we = rv_ff;
            if (rd_last) begin
               idx_in   = '0;
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (rv_ff && !done_ff[ri_ff] && (win_lo != '0) && (next_ff > win_lo)) begin
               done_in[ri_ff] = 1'b1;
               if (next_ff < win_hi) begin
                  next_in  = win_hi;
                  moved_in = 1'b1;
               end
            end
            if (rd_last) begin
               idx_in   = '0;
               // run another pass while the last one moved the fire time
               if (moved_in) begin
                  moved_in = 1'b0;
               end else begin
                  state_in = S_UPDATE;
               end
            end
         end
         S_UPDATE: begin
            if (rv_ff) begin
               row_we                = 1'b1;
               row_vld_in[row_iaddr] = 1'b1;
            end
            if (rd_last) begin
               idx_in   = '0;
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            if (!rsp_vld_ff || rsp_bus.ready) begin
               ft_we           = 1'b1;
               ft_waddr        = s_ff;
               ft_wdata        = next_ff;
               ft_vld_in[s_ff] = 1'b1;
               last_in         = s_ff;
               rsp_vld_in      = 1'b1;
               rsp_delay_in    = 32'(next_ff - cur_ff);
               rsp_time_in     = 32'(next_ff);
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         idx_ff     <= '0;
         rv_ff      <= 1'b0;
         moved_ff   <= 1'b0;
         done_ff    <= '0;
         ft_vld_ff  <= '0;
         row_vld_ff <= '0;
         off_ff     <= '0;
         last_ff    <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         rv_ff      <= rv_in;
         moved_ff   <= moved_in;
         done_ff    <= done_in;
         ft_vld_ff  <= ft_vld_in;
         row_vld_ff <= row_vld_in;
         off_ff     <= off_in;
         last_ff    <= last_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      ri_ff        <= ri_in;
      low_ff       <= low_in;
      now_ff       <= now_in;
      s_ff         <= s_in;
      cur_ff       <= cur_in;
      ftl_ff       <= ftl_in;
      passed_ff    <= passed_in;
      gap_ff       <= gap_in;
      ge_ff        <= ge_in;
      next_ff      <= next_in;
      rsp_delay_ff <= rsp_delay_in;
      rsp_time_ff  <= rsp_time_in;
   end

   sfts_ram #(.WIDTH(TB), .DEPTH(SENSORS)) u_fire_ram (
      .clock   (clock),
      .wr_en   (ft_we),
      .wr_addr (ft_waddr),
      .wr_data (ft_wdata),
      .rd_addr (ft_raddr),
      .rd_data (ft_rdata)
   );

   sfts_ram #(.WIDTH(TB), .DEPTH(RDEPTH)) u_row_ram (
      .clock   (clock),
      .wr_en   (row_we),
      .wr_addr (row_iaddr),
      .wr_data (row_wdata),
      .rd_addr (row_raddr),
      .rd_data (row_rdata)
   );

   sfts_ram #(.WIDTH(TB), .DEPTH(SENSORS)) u_win_ram (
      .clock   (clock),
      .wr_en   (win_we),
      .wr_addr (ri_ff),
      .wr_data (win_wdata),
      .rd_addr (idx_ff[IW-1:0]),
      .rd_data (win_rdata)
   );

endmodule

@@ sv/sfts_check.sv @@
`timescale 1ns / 1ps

module sfts_check (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic [sfts_pkg::FUNC_BITS-1:0]       req_func,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [sfts_pkg::DATA_BITS-1:0]       rsp_fire_delay,
   input logic [sfts_pkg::DATA_BITS-1:0]       rsp_fire_time
);

   // a waiting result beat holds until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fire_delay) &&
                                  $stable(rsp_fire_time))
      else $error("result beat changed while stalled");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // wrap, clear and unused items finish in the cycle they are taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_func != sfts_pkg::FUNC_SCHEDULE) |=> req_ready)
      else $error("non-schedule item held the input");

   // no result can appear the cycle after an item is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("result appeared without schedule work");

endmodule

bind sensor_fire_time_scheduler_unit sfts_check u_sfts_check (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .req_func       (req_bus.func),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_fire_delay (rsp_bus.fire_delay),
   .rsp_fire_time  (rsp_bus.fire_time)
);
